@@ hdl/bda_pkg.sv @@
`timescale 1ns / 1ps
// bda_pkg: shared types and constants for the box downsample averager.
// No dependencies.
package bda_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned PixW = 24;
  localparam int unsigned SumW = 32;
  localparam int unsigned CntW = 10;
  localparam int unsigned QuoW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SHRINK = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] count;
    logic            frame_end;
  } bda_job_t;
endpackage

@@ hdl/bda_front.sv @@
`timescale 1ns / 1ps
// bda_front: position tracking and block accumulation, one pixel per cycle while the job output is not stalled.
// Depends on bda_pkg.
module bda_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_SHRINK = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic [12:0]                width_i,
  input  logic [12:0]                height_i,
  input  logic [4:0]                 shrink_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [bda_pkg::PixW-1:0]   pixel_i,
  output logic                       job_valid_o,
  output bda_pkg::bda_job_t          job_o,
  input  logic                       job_ready_i
);
  import bda_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned SkW  = $clog2(MAX_SHRINK + 1);
  localparam int unsigned WbW  = $clog2(MAX_SHRINK);

  logic [SumW-1:0] col_mem [MAX_WIDTH];

  logic [12:0] width, height;
  logic [SkW-1:0] shrink;
  logic [12:0] col_q, row_q;
  logic [WbW-1:0] cwb_q, rwb_q;
  logic [ColW-1:0] bcol_q;
  logic [SumW-1:0] rsum_q;

  // stage 2 (memory read-modify-write)
  logic            s2_v_q, s2_rd_q, s2_out_q, s2_fe_q;
  logic [ColW-1:0] s2_bc_q;
  logic [SumW-1:0] s2_sum_q;
  logic [CntW-1:0] s2_cnt_q;
  logic [SumW-1:0] rd_q;
  logic            fwd_q;
  logic [SumW-1:0] fwd_sum_q;

  always_comb begin
    width = (width_i == 13'd0) ? 13'd1 :
            (32'(width_i) > MAX_WIDTH) ? 13'(MAX_WIDTH) : width_i;
    height = (height_i == 13'd0) ? 13'd1 : (height_i > 13'd4096) ? 13'd4096 : height_i;
    if (shrink_i == 5'd0) shrink = SkW'(1);
    else if (32'(shrink_i) > MAX_SHRINK) shrink = SkW'(MAX_SHRINK);
    else shrink = SkW'(shrink_i);
  end

  logic bad, last_col, last_row, bce, bre, fire;
  logic [12:0] col, row;
  logic [WbW-1:0] cwb, rwb;
  logic [ColW-1:0] bcol;
  logic [SumW-1:0] rsum, psum, s2_total;

  assign ready_o = !s2_v_q || !s2_out_q || job_ready_i;
  assign fire = valid_i && ready_o;

  always_comb begin
    bad = (col_q >= width) || (row_q >= height) ||
          (SkW'(cwb_q) >= shrink) || (SkW'(rwb_q) >= shrink);
    col  = bad ? '0 : col_q;
    row  = bad ? '0 : row_q;
    cwb  = bad ? '0 : cwb_q;
    rwb  = bad ? '0 : rwb_q;
    bcol = bad ? '0 : bcol_q;
    rsum = bad ? '0 : rsum_q;
    last_col = (col == width - 13'd1);
    last_row = (row == height - 13'd1);
    bce = last_col || (SkW'(cwb) == shrink - SkW'(1));
    bre = last_row || (SkW'(rwb) == shrink - SkW'(1));
    psum = rsum + SumW'(pixel_i);
    s2_total = s2_sum_q + (s2_rd_q ? (fwd_q ? fwd_sum_q : rd_q) : '0);
  end

  assign job_valid_o   = s2_v_q && s2_out_q;
  assign job_o.sum       = s2_total;
  assign job_o.count     = s2_cnt_q;
  assign job_o.frame_end = s2_fe_q;

  always_ff @(posedge clk_i) begin
    if (fire && bce) rd_q <= col_mem[bcol];
    if (s2_v_q && ready_o) col_mem[s2_bc_q] <= s2_total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; cwb_q <= '0; rwb_q <= '0; bcol_q <= '0;
      rsum_q <= '0; s2_v_q <= 1'b0; s2_rd_q <= 1'b0; s2_out_q <= 1'b0;
      s2_fe_q <= 1'b0; s2_bc_q <= '0; s2_sum_q <= '0; s2_cnt_q <= '0;
      fwd_q <= 1'b0; fwd_sum_q <= '0;
    end else if (restart_i) begin
      col_q <= '0; row_q <= '0; cwb_q <= '0; rwb_q <= '0; bcol_q <= '0;
      rsum_q <= '0;
    end else begin
      if (ready_o) s2_v_q <= fire && bce;
      if (fire) begin
        rsum_q <= bce ? '0 : psum;
        if (bce) begin
          s2_rd_q  <= (rwb != '0);
          s2_out_q <= bre;
          s2_fe_q  <= last_col && last_row;
          s2_bc_q  <= bcol;
          s2_sum_q <= psum;
          s2_cnt_q <= CntW'((32'(cwb) + 1) * (32'(rwb) + 1));
          fwd_q     <= s2_v_q && (s2_bc_q == bcol);
          fwd_sum_q <= s2_total;
        end
        if (last_col) begin
          col_q <= '0; cwb_q <= '0; bcol_q <= '0;
          if (last_row) begin
            row_q <= '0; rwb_q <= '0;
          end else begin
            row_q <= row + 13'd1;
            rwb_q <= bre ? '0 : rwb + WbW'(1);
          end
        end else begin
          col_q <= col + 13'd1;
          cwb_q <= bce ? '0 : cwb + WbW'(1);
          bcol_q <= bce ? bcol + ColW'(1) : bcol;
          row_q <= row; rwb_q <= rwb;
        end
      end
    end
  end
endmodule

@@ hdl/bda_queue.sv @@
`timescale 1ns / 1ps
// bda_queue: short job queue between accumulation and division.
// Depends on bda_pkg.
module bda_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bda_pkg::bda_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output bda_pkg::bda_job_t data_o,
  output logic              empty_o
);
  import bda_pkg::*;
  bda_job_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == 3'd4;
  assign empty_o = cnt_q == 3'd0;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 2'd1;
      if (do_pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
    end
  end
endmodule

@@ hdl/bda_divider.sv @@
`timescale 1ns / 1ps
// bda_divider: restoring divider, one quotient bit per cycle, result register.
// Depends on bda_pkg.
module bda_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  bda_pkg::bda_job_t        job_i,
  output logic                     pop_o,
  output logic [bda_pkg::PixW-1:0] average_value_o,
  output logic                     frame_end_o,
  output logic                     empty_o,
  input  logic                     pop_i
);
  import bda_pkg::*;
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_RUN = 3'b010, ST_DONE = 3'b100
  } div_state_e;

  div_state_e      state_q;
  logic [SumW-1:0] num_q;
  logic [SumW:0]   rem_q;
  logic [CntW-1:0] den_q;
  logic [5:0]      step_q;
  logic            fe_q;
  logic [SumW:0]   trial;
  logic            ge;

  assign trial = {rem_q[SumW-1:0], num_q[SumW-1]};
  assign ge    = trial >= (SumW+1)'(den_q);
  assign pop_o = (state_q == ST_IDLE) && !empty_i;
  assign empty_o = state_q != ST_DONE;
  assign frame_end_o = fe_q;
  assign average_value_o = num_q[PixW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; step_q <= '0;
      num_q <= '0; rem_q <= '0; den_q <= '0; fe_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            num_q <= job_i.sum; den_q <= job_i.count; fe_q <= job_i.frame_end;
            rem_q <= '0; step_q <= '0; state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem_q <= ge ? trial - (SumW+1)'(den_q) : trial;
          num_q <= {num_q[SumW-2:0], ge};
          step_q <= step_q + 6'd1;
          if (step_q == 6'(SumW - 1)) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (pop_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/box_downsample_average.sv @@
`timescale 1ns / 1ps
// box_downsample_average: top level of the box-filter downsampler.
// Depends on bda_pkg, bda_front, bda_queue, bda_divider.
//
//  port group         dir  handshake
//  pixel_value_i      in   push / full
//  average, frame_end out  empty / pop
//  cfg_*              in   cfg_we_i
//
// The front takes one pixel per cycle unless stalled. Each block result goes
// through a 32-step divider that takes no new job until its result is popped; the queue
// absorbs bursts, and a full queue stalls the front.
// Reset clears all counters; block column sums need no clearing.
module box_downsample_average #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_SHRINK = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bda_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bda_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [23:0]                     pixel_value_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [23:0]                     average_value_o,
  output logic                            frame_end_o
);
  import bda_pkg::*;

  logic [12:0] width_q, height_q;
  logic [4:0]  shrink_q;
  logic        restart;
  logic        ready, jv, q_full, q_empty, q_pop;
  bda_job_t    job, qjob;

  assign restart = cfg_we_i && (cfg_idx_e'(cfg_index_i) != CFG_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 13'd1; height_q <= 13'd1; shrink_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_SHRINK: shrink_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign full = !ready;

  bda_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_SHRINK(MAX_SHRINK)) u_front (
    .clk_i, .rst_ni, .restart_i(restart), .width_i(width_q), .height_i(height_q),
    .shrink_i(shrink_q), .valid_i(push), .ready_o(ready), .pixel_i(pixel_value_i),
    .job_valid_o(jv), .job_o(job), .job_ready_i(!q_full)
  );

  bda_queue u_queue (
    .clk_i, .rst_ni, .push_i(jv), .data_i(job), .full_o(q_full),
    .pop_i(q_pop), .data_o(qjob), .empty_o(q_empty)
  );

  bda_divider u_div (
    .clk_i, .rst_ni, .empty_i(q_empty), .job_i(qjob), .pop_o(q_pop),
    .average_value_o, .frame_end_o, .empty_o(empty), .pop_i(pop)
  );

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (jv && q_full) |-> full) else $error("front not stalled on full queue");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(average_value_o))) else $error("result lost");
endmodule

@@ tb/sv/box_downsample_average_tb.sv @@
`timescale 1ns / 1ps
// box_downsample_average_tb: self-checking bench for the box downsampler.
// Depends on bda_pkg and box_downsample_average; predicts block means in-line.
module box_downsample_average_tb;
  import bda_pkg::*;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxShrink = 16;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned DrainWait = 200;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned ItemTarget = 950;

  typedef struct {
    logic [PixW-1:0] average;
    logic            frame_end;
  } block_mean_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                push;
  logic                full;
  logic [PixW-1:0]     pixel_value_i;
  logic                empty;
  logic                pop;
  logic [PixW-1:0]     average_value_o;
  logic                frame_end_o;

  box_downsample_average DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .pixel_value_i   (pixel_value_i),
    .empty           (empty),
    .pop             (pop),
    .average_value_o (average_value_o),
    .frame_end_o     (frame_end_o)
  );

  // predictor state
  logic [CfgDataW-1:0] width_reg, height_reg;
  logic [4:0]          shrink_reg;
  logic [SumW-1:0]     col_sums [MaxWidth];
  logic [SumW-1:0]     row_sum;
  int unsigned         col_pos, row_pos, col_in_blk, row_in_blk;

  logic [PixW-1:0] pixel_q [$];
  block_mean_t     mean_q [$];
  int unsigned     errors;
  int unsigned     idle_cycles;
  int unsigned     sent;
  bit              hold_req;
  int unsigned     hold_left, mode_left, pop_mode;
  int unsigned     burst_left, gap_left;

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    row_sum = '0;
    col_pos = 0;
    row_pos = 0;
    col_in_blk = 0;
    row_in_blk = 0;
  endfunction

  function automatic void send_pixel(logic [PixW-1:0] px);
    pixel_q = {pixel_q, px};
    sent++;
  endfunction

  function automatic void predict_mean(logic [PixW-1:0] px);
    int unsigned     w, h, s, blk_col, cnt;
    bit              last_col, last_row, col_end, row_end;
    logic [SumW-1:0] sum;
    block_mean_t     m;
    w = clamp(width_reg, MaxWidth);
    h = clamp(height_reg, MaxHeight);
    s = clamp(shrink_reg, MaxShrink);
    if (col_pos >= w || row_pos >= h || col_in_blk >= s || row_in_blk >= s)
      restart_frame();
    last_col = (col_pos == w - 1);
    last_row = (row_pos == h - 1);
    col_end = last_col || (col_in_blk == s - 1);
    row_end = last_row || (row_in_blk == s - 1);
    blk_col = (col_pos / s) % MaxWidth;
    row_sum = row_sum + px;
    if (col_end) begin
      sum = row_sum;
      if (row_in_blk != 0) sum = sum + col_sums[blk_col];
      col_sums[blk_col] = sum;
      row_sum = '0;
      if (row_end) begin
        cnt = (col_in_blk + 1) * (row_in_blk + 1);
        m.average = PixW'(sum / cnt);
        m.frame_end = last_col && last_row;
        mean_q = {mean_q, m};
      end
    end
    if (last_col) begin
      col_pos = 0;
      col_in_blk = 0;
      if (last_row) begin
        row_pos = 0;
        row_in_blk = 0;
      end else begin
        row_pos++;
        row_in_blk = row_end ? 0 : row_in_blk + 1;
      end
    end else begin
      col_pos++;
      col_in_blk = col_end ? 0 : col_in_blk + 1;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // accept requests and check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || cfg_we_i || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (push && !full) begin
        predict_mean(pixel_value_i);
        void'(pixel_q.pop_front());
      end
      if (pop && !empty) begin
        if (mean_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result average=%h frame_end=%b", $time,
                   average_value_o, frame_end_o);
        end else begin
          if (average_value_o !== mean_q[0].average) begin
            errors++;
            $display("%0t: average expected %h actual %h", $time,
                     mean_q[0].average, average_value_o);
          end
          if (frame_end_o !== mean_q[0].frame_end) begin
            errors++;
            $display("%0t: frame_end expected %b actual %b", $time,
                     mean_q[0].frame_end, frame_end_o);
          end
          void'(mean_q.pop_front());
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // driver: bursts with gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && full && pixel_q.size() > 0) begin
        pixel_value_i <= pixel_q[0];
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        push <= 1'b1;
        pixel_value_i <= pixel_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req <= 1'b0;
        hold_left <= 900;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left <= $urandom_range(20, 120);
          pop_mode <= $urandom_range(0, 2);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (pop_mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 1) == 0);
          default: pop <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(value);
    case (idx)
      CFG_WIDTH:  width_reg = CfgDataW'(value);
      CFG_HEIGHT: height_reg = CfgDataW'(value);
      CFG_SHRINK: shrink_reg = 5'(value);
      default: ;
    endcase
    if (idx != CFG_NONE) restart_frame();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned s);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_SHRINK, s);
  endtask

  function automatic logic [PixW-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return PixW'($urandom);
    endcase
  endfunction

  task automatic drain();
    while (pixel_q.size() > 0 || mean_q.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    int unsigned w, h, s, n, phase;
    bit          saturate;
    errors = 0;
    idle_cycles = 0;
    sent = 0;
    hold_req = 1'b0;
    hold_left = 0;
    mode_left = 0;
    pop_mode = 0;
    burst_left = 1;
    gap_left = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_NONE;
    cfg_data_i = '0;
    push = 1'b0;
    pixel_value_i = '0;
    pop = 1'b0;
    width_reg = 1;
    height_reg = 1;
    shrink_reg = 1;
    foreach (col_sums[i]) col_sums[i] = '0;
    restart_frame();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset geometry: every pixel is its own frame
    send_pixel('0);
    send_pixel('1);
    send_pixel(24'h800000);
    drain();
    write_reg(CFG_NONE, 13'h1fff);
    set_geometry(0, 0, 0);
    send_pixel(24'h000001);
    send_pixel(24'h7fffff);
    drain();
    set_geometry(5, 3, 2);
    repeat (15) send_pixel('1);
    drain();
    set_geometry(8191, 1, 31);
    repeat (20) send_pixel(rand_pixel());
    drain();
    set_geometry(2, 8191, 16);
    repeat (6) send_pixel(rand_pixel());
    drain();

    // largest full block at full scale
    set_geometry(16, 16, 16);
    repeat (256) send_pixel('1);
    drain();

    phase = 0;
    while (sent < ItemTarget) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(0, 1) ? 4096 : $urandom_range(4097, 8191);
        h = $urandom_range(0, 1);
      end else begin
        w = $urandom_range(0, 24);
        h = $urandom_range(0, 12);
      end
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      if (phase == 2) s = 1;
      set_geometry(w, h, s);
      n = clamp(w, MaxWidth) * clamp(h, MaxHeight);
      if (n > 120 || $urandom_range(0, 3) == 0) n = $urandom_range(1, 90);
      else n = n * $urandom_range(1, 2);
      if (phase == 2) begin
        hold_req <= 1'b1;
        n = n < 100 ? 100 : n;
      end
      if (n > ItemTarget - sent) n = ItemTarget - sent;
      saturate = ($urandom_range(0, 7) == 0);
      repeat (n) send_pixel(saturate ? '1 : rand_pixel());
      phase++;
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
